/* hw/rtl/rbds_pkg.sv */
package rbds_pkg;

   localparam int MAX_OUT_WIDTH = 160;
   localparam int LINE_AW       = $clog2(MAX_OUT_WIDTH);
   localparam int COL_W         = $clog2(2 * MAX_OUT_WIDTH);

   localparam int SUM_W    = 18;
   localparam int PIXEL_W  = 16;
   localparam int TILE_W   = 7;
   localparam int OFFSET_W = 16;
   localparam int PROD_W   = 17;
   localparam int WIDTH_W  = 8;
   localparam int HEIGHT_W = 7;
   localparam int TROWS_W  = 7;
   localparam int STRIDE_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE = 2'd3;

   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd160;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd105;
   localparam logic [TROWS_W-1:0]  TROWS_RST  = 7'd105;
   localparam logic [STRIDE_W-1:0] STRIDE_RST = 10'd160;

   // effective settings: width clamped, height and tile rows never zero
   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [TROWS_W-1:0]  trows;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [LINE_AW-1:0] addr;
      logic [SUM_W-1:0]   wdata;
   } mem_req_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [TILE_W-1:0]  tile;
      logic [PROD_W-1:0]  prod;
      logic [WIDTH_W-1:0] col;
      logic               rit_odd;
      logic               last;
   } stage_type;

   // per-field sums of two pixels: red 17-12, green 11-6, blue 5-0
   function automatic logic [SUM_W-1:0] pair_sum(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
      logic [5:0] r;
      logic [5:0] g;
      logic [5:0] bl;
      r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
      g  = {1'b0, a[10:6]}  + {1'b0, b[10:6]};
      bl = {1'b0, a[5:1]}   + {1'b0, b[5:1]};
      return {r, g, bl};
   endfunction

   // combine two pair sums, divide by four, force alpha
   function automatic logic [PIXEL_W-1:0] box_pixel(input logic [SUM_W-1:0] t,
                                                    input logic [SUM_W-1:0] s);
      logic [6:0] r;
      logic [6:0] g;
      logic [6:0] bl;
      r  = {1'b0, t[17:12]} + {1'b0, s[17:12]};
      g  = {1'b0, t[11:6]}  + {1'b0, s[11:6]};
      bl = {1'b0, t[5:0]}   + {1'b0, s[5:0]};
      return {r[6:2], g[6:2], bl[6:2], 1'b1};
   endfunction

endpackage

/* hw/rtl/rbds_line_mem.sv */
module rbds_line_mem (
   input  logic                                clock,
   input  rbds_pkg::mem_req_type               mem_req,
   output logic [rbds_pkg::SUM_W-1:0]          rd_data
);

   logic [rbds_pkg::SUM_W-1:0] line_mem [rbds_pkg::MAX_OUT_WIDTH];
   logic [rbds_pkg::SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         line_mem[mem_req.addr] <= mem_req.wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= line_mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rbds_front.sv */
module rbds_front (
   input  logic                              clock,
   input  logic                              reset,
   input  rbds_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rbds_pkg::PIXEL_W-1:0]      req_src_pixel,
   input  logic                              out_free,
   output rbds_pkg::mem_req_type             mem_req,
   output logic                              s1_valid,
   output rbds_pkg::stage_type               s1
);

   logic [rbds_pkg::COL_W-1:0]    src_column_ff, src_column_in;
   logic                          src_row_odd_ff, src_row_odd_in;
   logic [rbds_pkg::HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [rbds_pkg::TROWS_W-1:0]  row_in_tile_ff, row_in_tile_in;
   logic [rbds_pkg::TILE_W-1:0]   tile_count_ff, tile_count_in;
   logic [rbds_pkg::PIXEL_W-1:0]  first_ff, first_in;
   logic                          s1_valid_ff, s1_valid_in;
   rbds_pkg::stage_type           s1_ff, s1_in;

   logic                          accept;
   logic                          emit;
   logic [rbds_pkg::COL_W-1:0]    two_w;
   logic [rbds_pkg::COL_W-1:0]    col_now;
   logic [rbds_pkg::COL_W-1:0]    col_next;
   logic [rbds_pkg::WIDTH_W-1:0]  col;
   logic [rbds_pkg::SUM_W-1:0]    sum;
   logic                          rows_done;
   logic                          last_col;
   logic [rbds_pkg::TROWS_W:0]    rit_next;

   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign two_w    = rbds_pkg::COL_W'({cfg.width, 1'b0});
   // a column left beyond the width by a config change restarts the row
   assign col_now  = (src_column_ff >= two_w) ? '0 : src_column_ff;
   assign col      = col_now[rbds_pkg::COL_W-1:1];
   assign col_next = col_now + 1'b1;
   assign sum      = rbds_pkg::pair_sum(first_ff, req_src_pixel);
   assign emit     = accept && col_now[0] && src_row_odd_ff;

   assign rows_done = ({1'b0, out_row_ff} + 1'b1) >= {1'b0, cfg.height};
   assign last_col  = ({1'b0, col} + 1'b1) == {1'b0, cfg.width};
   assign rit_next  = {1'b0, row_in_tile_ff} + 1'b1;

   always_comb begin
      mem_req.we    = accept && col_now[0] && !src_row_odd_ff;
      mem_req.re    = emit;
      mem_req.addr  = col[rbds_pkg::LINE_AW-1:0];
      mem_req.wdata = sum;
   end

   always_comb begin
      src_column_in  = src_column_ff;
      src_row_odd_in = src_row_odd_ff;
      out_row_in     = out_row_ff;
      row_in_tile_in = row_in_tile_ff;
      tile_count_in  = tile_count_ff;
      first_in       = first_ff;
      if (accept) begin
         if (!col_now[0]) begin
            first_in = req_src_pixel;
         end
         if (col_next >= two_w) begin
            src_column_in = '0;
            if (!src_row_odd_ff) begin
               src_row_odd_in = 1'b1;
            end else begin
               src_row_odd_in = 1'b0;
               if (rows_done) begin
                  out_row_in     = '0;
                  row_in_tile_in = '0;
                  tile_count_in  = '0;
               end else begin
                  out_row_in = out_row_ff + 1'b1;
                  if (rit_next >= {1'b0, cfg.trows}) begin
                     row_in_tile_in = '0;
                     tile_count_in  = tile_count_ff + 1'b1;
                  end else begin
                     row_in_tile_in = rit_next[rbds_pkg::TROWS_W-1:0];
                  end
               end
            end
         end else begin
            src_column_in = col_next;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in   = emit;
         s1_in.sum     = sum;
         s1_in.tile    = tile_count_ff;
         s1_in.prod    = rbds_pkg::PROD_W'(row_in_tile_ff) * rbds_pkg::PROD_W'(cfg.stride);
         s1_in.col     = col;
         s1_in.rit_odd = row_in_tile_ff[0];
         s1_in.last    = last_col && rows_done;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_column_ff  <= '0;
         src_row_odd_ff <= 1'b0;
         out_row_ff     <= '0;
         row_in_tile_ff <= '0;
         tile_count_ff  <= '0;
         first_ff       <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         src_column_ff  <= src_column_in;
         src_row_odd_ff <= src_row_odd_in;
         out_row_ff     <= out_row_in;
         row_in_tile_ff <= row_in_tile_in;
         tile_count_ff  <= tile_count_in;
         first_ff       <= first_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("line memory written and read in one cycle");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled stage item changed");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      src_column_ff < rbds_pkg::COL_W'(2 * rbds_pkg::MAX_OUT_WIDTH))
      else $error("source column out of range");

   a_result_needs_read: assert property (@(posedge clock) disable iff (reset)
      accept && !emit |=> !s1_valid_ff)
      else $error("stage marked valid without a line read");

endmodule

/* hw/rtl/rbds_back.sv */
module rbds_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               s1_valid,
   input  rbds_pkg::stage_type                s1,
   input  logic [rbds_pkg::SUM_W-1:0]         rd_data,
   output logic                               out_free,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rbds_pkg::TILE_W-1:0]        rsp_tile_index,
   output logic [rbds_pkg::OFFSET_W-1:0]      rsp_element_offset,
   output logic [rbds_pkg::PIXEL_W-1:0]       rsp_out_pixel,
   output logic                               rsp_frame_last
);

   logic                            valid_ff, valid_in;
   logic [rbds_pkg::TILE_W-1:0]     tile_ff;
   logic [rbds_pkg::OFFSET_W-1:0]   offset_ff, offset_in;
   logic [rbds_pkg::PIXEL_W-1:0]    pixel_ff, pixel_in;
   logic                            last_ff;
   logic [rbds_pkg::PROD_W-1:0]     off_full;
   logic                            load;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = s1_valid && out_free;

   assign off_full  = s1.prod + rbds_pkg::PROD_W'(s1.col);
   // odd tile rows swap the halves of each 64-bit word
   assign offset_in = off_full[rbds_pkg::OFFSET_W-1:0]
                      ^ {{(rbds_pkg::OFFSET_W-2){1'b0}}, s1.rit_odd, 1'b0};
   assign pixel_in  = rbds_pkg::box_pixel(rd_data, s1.sum);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tile_ff   <= s1.tile;
         offset_ff <= offset_in;
         pixel_ff  <= pixel_in;
         last_ff   <= s1.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_tile_index     = tile_ff;
   assign rsp_element_offset = offset_ff;
   assign rsp_out_pixel      = pixel_ff;
   assign rsp_frame_last     = last_ff;

endmodule

/* hw/rtl/rgba5551_box_downsample_tiled.sv */
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_src_pixel
// rsp      out        rsp_valid/rsp_ready    rsp_tile_index, rsp_element_offset,
//                                            rsp_out_pixel, rsp_frame_last
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One source pixel per cycle while req_ready is high; each second pixel of a pair
// in an odd source row yields a result (line read and stage, then output register).
// The 160-entry line memory is written in even rows and read in odd rows,
// one access per pixel pair, through a single shared address.
// Synchronous reset clears counters and valid flags; line memory is not cleared.
// req_ready drops only when both the stage and output register hold items
// and rsp_ready is low. csr_ready is always high.
module rgba5551_box_downsample_tiled (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rbds_pkg::PIXEL_W-1:0]          req_src_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rbds_pkg::TILE_W-1:0]           rsp_tile_index,
   output logic [rbds_pkg::OFFSET_W-1:0]         rsp_element_offset,
   output logic [rbds_pkg::PIXEL_W-1:0]          rsp_out_pixel,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rbds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rbds_pkg::CSR_DATA_W-1:0]       csr_data
);

   rbds_pkg::cfg_type            cfg_ff, cfg_in;
   rbds_pkg::mem_req_type        mem_req;
   rbds_pkg::stage_type          s1;
   logic                         s1_valid;
   logic                         out_free;
   logic [rbds_pkg::SUM_W-1:0]   rd_data;
   logic [rbds_pkg::WIDTH_W-1:0] wr_width;

   assign csr_ready = 1'b1;
   assign wr_width  = csr_data[rbds_pkg::WIDTH_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rbds_pkg::CSR_OUT_WIDTH: begin
               if (wr_width == '0) begin
                  cfg_in.width = rbds_pkg::WIDTH_W'(1);
               end else if (wr_width > rbds_pkg::WIDTH_W'(rbds_pkg::MAX_OUT_WIDTH)) begin
                  cfg_in.width = rbds_pkg::WIDTH_W'(rbds_pkg::MAX_OUT_WIDTH);
               end else begin
                  cfg_in.width = wr_width;
               end
            end
            rbds_pkg::CSR_OUT_HEIGHT: begin
               cfg_in.height = (csr_data[rbds_pkg::HEIGHT_W-1:0] == '0)
                               ? rbds_pkg::HEIGHT_W'(1) : csr_data[rbds_pkg::HEIGHT_W-1:0];
            end
            rbds_pkg::CSR_TILE_ROWS: begin
               cfg_in.trows = (csr_data[rbds_pkg::TROWS_W-1:0] == '0)
                              ? rbds_pkg::TROWS_W'(1) : csr_data[rbds_pkg::TROWS_W-1:0];
            end
            rbds_pkg::CSR_ROW_STRIDE: begin
               cfg_in.stride = csr_data[rbds_pkg::STRIDE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= rbds_pkg::WIDTH_RST;
         cfg_ff.height <= rbds_pkg::HEIGHT_RST;
         cfg_ff.trows  <= rbds_pkg::TROWS_RST;
         cfg_ff.stride <= rbds_pkg::STRIDE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbds_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_pixel (req_src_pixel),
      .out_free      (out_free),
      .mem_req       (mem_req),
      .s1_valid      (s1_valid),
      .s1            (s1)
   );

   rbds_line_mem u_line_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rbds_back u_back (
      .clock              (clock),
      .reset              (reset),
      .s1_valid           (s1_valid),
      .s1                 (s1),
      .rd_data            (rd_data),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_tile_index     (rsp_tile_index),
      .rsp_element_offset (rsp_element_offset),
      .rsp_out_pixel      (rsp_out_pixel),
      .rsp_frame_last     (rsp_frame_last)
   );

endmodule
